// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Antecedent at one edge requires the consequent at the next edge.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/mma_pkg.sv =====
`default_nettype none

package mma_pkg;

   localparam int MAX_MESSAGE_BYTES = 32;
   localparam int ADDR_W = $clog2(MAX_MESSAGE_BYTES);
   localparam int CNT_W = $clog2(MAX_MESSAGE_BYTES + 1);

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW = $clog2(FIFO_DEPTH);

   // Byte codes.
   localparam logic [7:0] BYTE_8F = 8'h8F;
   localparam logic [7:0] STATUS_SYSEX = 8'hF0;
   localparam logic [7:0] STATUS_EOX = 8'hF7;
   localparam logic [7:0] STATUS_MTC = 8'hF1;
   localparam logic [7:0] STATUS_SONG_POS = 8'hF2;
   localparam logic [7:0] STATUS_SONG_SEL = 8'hF3;

   // Upper nibbles of status bytes.
   localparam logic [3:0] HI_PROGRAM = 4'hC;
   localparam logic [3:0] HI_CH_PRESSURE = 4'hD;
   localparam logic [3:0] HI_SYSTEM = 4'hF;

   // Command from the front end to the back end: an optional buffer write,
   // followed by an optional emission of the first len bytes.
   typedef struct packed {
      logic              wr;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
      logic              emit;
      logic [CNT_W-1:0]  len;
   } cmd_type;

endpackage

`default_nettype wire

// ===== rtl/mma_ram.sv =====
`default_nettype none

module mma_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/mma_front.sv =====
`default_nettype none
`include "assert_macros.svh"

module mma_front import mma_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_midi_in_byte,
   input  wire logic       port_open,
   input  wire logic       cmd_full,
   output logic            cmd_push,
   output cmd_type         cmd
);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       status_ff, status_in;
   logic [7:0]       last_ff, last_in;

   logic             accept;
   logic             restart, do_app, overflow, wr;
   logic [CNT_W-1:0] base, n, need;
   logic             has_need, complete, clr, emit;
   logic [7:0]       b, s;

   assign b = req_midi_in_byte;
   assign accept = req_valid && !cmd_full;
   assign req_stall = cmd_full;

   always_comb begin
      restart = 1'b0;
      do_app = 1'b0;
      if (b == BYTE_8F) begin
         do_app = (count_ff >= CNT_W'(2));
      end else if (b[7]) begin
         if (b == STATUS_EOX && count_ff != '0 && status_ff == STATUS_SYSEX) begin
            do_app = 1'b1;
         end else begin
            restart = 1'b1;
            do_app = 1'b1;
         end
      end else begin
         do_app = (count_ff != '0);
      end

      base = restart ? '0 : count_ff;
      overflow = do_app && (base >= CNT_W'(MAX_MESSAGE_BYTES));
      wr = do_app && !overflow;
      n = overflow ? '0 : (wr ? base + CNT_W'(1) : base);
      s = restart ? b : status_ff;
      last_in = wr ? b : last_ff;

      need = CNT_W'(3);
      has_need = 1'b0;
      complete = 1'b0;
      clr = 1'b0;
      if (n != '0) begin
         if (!s[7]) begin
            clr = 1'b1;
         end else if (s[7:4] != HI_SYSTEM) begin
            has_need = 1'b1;
            if (s[7:4] == HI_PROGRAM || s[7:4] == HI_CH_PRESSURE) begin
               need = CNT_W'(2);
            end
         end else begin
            case (s)
               STATUS_SYSEX: begin
                  complete = (last_in == STATUS_EOX);
               end
               STATUS_SONG_POS: begin
                  has_need = 1'b1;
               end
               STATUS_SONG_SEL: begin
                  has_need = 1'b1;
                  need = CNT_W'(2);
               end
               STATUS_MTC, STATUS_EOX: begin
                  clr = 1'b1;
               end
               default: begin
                  complete = 1'b1;
               end
            endcase
         end
         if (has_need) begin
            if (n == need) begin
               complete = 1'b1;
            end else if (n > need) begin
               clr = 1'b1;
            end
         end
      end

      emit = complete && (n > CNT_W'(1)) && port_open;
      count_in = (complete || clr) ? '0 : n;
      status_in = s;
   end

   assign cmd_push = accept && (wr || emit);
   assign cmd.wr = wr;
   assign cmd.addr = base[ADDR_W-1:0];
   assign cmd.data = b;
   assign cmd.emit = emit;
   assign cmd.len = n;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         last_ff <= last_in;
      end
   end

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(MAX_MESSAGE_BYTES))

endmodule

`default_nettype wire

// ===== rtl/mma_cmd_fifo.sv =====
`default_nettype none
`include "assert_macros.svh"

module mma_cmd_fifo import mma_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   input  wire logic    pop,
   output cmd_type      head,
   output logic         full,
   output logic         empty
);

   cmd_type              q_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wp_ff, rp_ff;
   logic [FIFO_AW:0]     cnt_ff, cnt_in;

   assign full = (cnt_ff == (FIFO_AW + 1)'(FIFO_DEPTH));
   assign empty = (cnt_ff == '0);
   assign head = q_ff[rp_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wp_ff <= wp_ff + 1'b1;
         end
         if (pop) begin
            rp_ff <= rp_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= push_cmd;
      end
   end

   `ASSERT_ALWAYS(a_no_overrun, clock, reset, !(push && full))
   `ASSERT_ALWAYS(a_no_underrun, clock, reset, !(pop && empty))

endmodule

`default_nettype wire

// ===== rtl/mma_back.sv =====
`default_nettype none
`include "assert_macros.svh"

module mma_back import mma_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    cmd_valid,
   input  wire cmd_type head,
   output logic         cmd_pop,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output logic [7:0]   rsp_midi_out_byte,
   output logic         rsp_last_byte
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_LOAD = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [ADDR_W-1:0] rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]  len_ff, len_in;
   logic              out_valid_ff, out_valid_in;
   logic [7:0]        out_byte_ff;
   logic              out_last_ff;
   logic [7:0]        rd_data;
   logic              out_free, load, is_last;

   mma_ram #(
      .WIDTH(8),
      .DEPTH(MAX_MESSAGE_BYTES)
   ) u_store (
      .clock  (clock),
      .wr_en  (cmd_pop && head.wr),
      .wr_addr(head.addr),
      .wr_data(head.data),
      .rd_en  (state_ff == ST_READ),
      .rd_addr(rd_idx_ff),
      .rd_data(rd_data)
   );

   assign out_free = !out_valid_ff || !rsp_stall;
   assign cmd_pop = (state_ff == ST_IDLE) && cmd_valid;
   assign load = (state_ff == ST_LOAD) && out_free;
   assign is_last = ((CNT_W'(rd_idx_ff) + CNT_W'(1)) == len_ff);

   always_comb begin
      state_in = state_ff;
      rd_idx_in = rd_idx_ff;
      len_in = len_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_pop && head.emit) begin
               len_in = head.len;
               rd_idx_in = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (load) begin
               if (is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_idx_in = rd_idx_ff + 1'b1;
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      len_ff <= len_in;
      if (load) begin
         out_byte_ff <= rd_data;
         out_last_ff <= is_last;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_midi_out_byte = out_byte_ff;
   assign rsp_last_byte = out_last_ff;

   `ASSERT_ALWAYS(a_idx_in_msg, clock, reset,
      (state_ff == ST_IDLE) || (CNT_W'(rd_idx_ff) < len_ff))
   `ASSERT_NEXT(a_pop_only_idle, clock, reset, state_ff != ST_IDLE, !cmd_pop || state_ff == ST_IDLE)

endmodule

`default_nettype wire

// ===== rtl/midi_message_assembler_top.sv =====
// MIDI message assembler.
// Received MIDI bytes enter one per transaction on the req_ channel
// (req_valid, req_stall, req_midi_in_byte). Completed messages leave on the
// rsp_ channel as one transaction per byte, in order, with rsp_last_byte set
// on the final byte. A transaction moves when valid is high and stall is low.
// The APB-style port holds one register, port_open, at byte address 0; only
// while it is 1 are completed messages sent out.
// The front end takes one byte per cycle while the queue is not full and
// classifies it in that cycle. Each byte that must be stored or that
// completes a message becomes a command in a four-entry queue. The back
// end takes one command per cycle while idle, then sends the message with
// one buffer memory read and one output load per byte; the byte read goes
// from the buffer memory into the output register in the load step.
// When the receiver stalls, the output register holds its byte, the back end
// waits, and once the queue fills the front end raises req_stall.
// Reset empties the message buffer count, the queue and the output register
// and closes the port. The buffer memory itself is not cleared.
`default_nettype none

module midi_message_assembler_top import mma_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_midi_in_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_midi_out_byte,
   output logic             rsp_last_byte,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   // Register index taken from the word address.
   localparam logic REG_PORT_OPEN = 1'b0;

   logic    port_open_ff;
   logic    csr_write;
   logic    cmd_push, cmd_pop, cmd_full, cmd_empty;
   cmd_type cmd, head;

   // Configuration register; writes to other addresses are ignored.
   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         port_open_ff <= 1'b0;
      end else if (csr_write && paddr[2] == REG_PORT_OPEN) begin
         port_open_ff <= pwdata[0];
      end
   end

   assign prdata = (paddr[2] == REG_PORT_OPEN) ? {31'd0, port_open_ff} : 32'd0;

   // The front end tracks the message count, status byte and last byte held.
   mma_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_midi_in_byte(req_midi_in_byte),
      .port_open       (port_open_ff),
      .cmd_full        (cmd_full),
      .cmd_push        (cmd_push),
      .cmd             (cmd)
   );

   mma_cmd_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .push_cmd(cmd),
      .pop     (cmd_pop),
      .head    (head),
      .full    (cmd_full),
      .empty   (cmd_empty)
   );

   // The back end owns the buffer memory, so writes for the next message
   // wait in the queue until the current emission has read its bytes.
   mma_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (!cmd_empty),
      .head             (head),
      .cmd_pop          (cmd_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_midi_out_byte(rsp_midi_out_byte),
      .rsp_last_byte    (rsp_last_byte)
   );

endmodule

`default_nettype wire
